@@ hw/rtl/image_rotate_90_clockwise_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the image rotation core
// Shared property shapes, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_90_CLOCKWISE_CORE_ASSERT_SVH
`define IMAGE_ROTATE_90_CLOCKWISE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/irc_pkg.sv @@
// ----------------------------------------------------------------------------
// irc_pkg
// Types and codes shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package irc_pkg;

  // Item kinds carried on in_tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // Width of a dimension register value on the configuration port.
  localparam int unsigned CFG_DATA_W = 7;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_pixel;
    logic rd_pixel;
  } cmd_t;

endpackage

@@ hw/rtl/irc_ctrl.sv @@
// ----------------------------------------------------------------------------
// irc_ctrl
// Handshake controller: accepts items and tracks whether a result is shown.
// ----------------------------------------------------------------------------
module irc_ctrl
  import irc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid & in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a read enters SHOW, a taken result without a new read leaves it.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_READ) begin
          state_nxt = ST_SHOW;
        end
      end
      ST_SHOW: begin
        if (out_ready) begin
          state_nxt = (accept && in_op == OP_READ) ? ST_SHOW : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: a new item is taken whenever the output slot is free or drains now.
  always_comb begin
    in_ready     = 1'b1;
    out_valid    = 1'b0;
    cmd.wr_pixel = 1'b0;
    cmd.rd_pixel = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SHOW: begin
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.wr_pixel = in_valid & in_ready & (in_op == OP_WRITE);
    cmd.rd_pixel = in_valid & in_ready & (in_op == OP_READ);
  end

endmodule

@@ hw/rtl/irc_dp.sv @@
// ----------------------------------------------------------------------------
// irc_dp
// Datapath: dimension registers, write and read counters, and the pixel store.
// ----------------------------------------------------------------------------
module irc_dp
  import irc_pkg::*;
#(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [PIXEL_BITS-1:0] pixel_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [PIXEL_BITS-1:0] pixel_out,
  output logic                  last_out
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned TOT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned RST_DIM  = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam int unsigned RST_TOT  = RST_DIM * RST_DIM;
  localparam int unsigned RST_BASE = RST_DIM * (RST_DIM - 1);

  logic [DIM_W-1:0]      rows_r;
  logic [DIM_W-1:0]      cols_r;
  logic [TOT_W-1:0]      total_r;
  logic [ADDR_W-1:0]     base_r;
  logic [ADDR_W-1:0]     wr_idx_r;
  logic [IDX_W-1:0]      row_r;
  logic [IDX_W-1:0]      col_r;
  logic [ADDR_W-1:0]     src_r;

  logic [DIM_W-1:0]      clamp_dim;
  logic [DIM_W-1:0]      rows_nxt;
  logic [DIM_W-1:0]      cols_nxt;
  logic [TOT_W-1:0]      total_nxt;
  logic [ADDR_W-1:0]     base_nxt;
  logic                  cfg_hit;
  logic                  wr_wrap;
  logic                  col_end;
  logic                  row_end;

  logic [PIXEL_BITS-1:0] mem [DEPTH];

  // Saturate the written dimension into 1..MAX_DIM.
  always_comb begin
    if (cfg_data == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (32'(cfg_data) > MAX_DIM) begin
      clamp_dim = DIM_W'(MAX_DIM);
    end else begin
      clamp_dim = DIM_W'(cfg_data);
    end
  end

  // New dimensions, and the image size and last-row base that follow from them.
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    cfg_hit  = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: begin
          rows_nxt = clamp_dim;
          cfg_hit  = 1'b1;
        end
        REG_COLS: begin
          cols_nxt = clamp_dim;
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    total_nxt = TOT_W'(rows_nxt) * TOT_W'(cols_nxt);
    base_nxt  = ADDR_W'(total_nxt - TOT_W'(cols_nxt));
  end

  // Counter wrap points.
  assign wr_wrap = (TOT_W'(wr_idx_r) + TOT_W'(1)) == total_r;
  assign col_end = (DIM_W'(col_r) + DIM_W'(1)) == rows_r;
  assign row_end = (DIM_W'(row_r) + DIM_W'(1)) == cols_r;

  // Configuration and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= DIM_W'(RST_DIM);
      cols_r   <= DIM_W'(RST_DIM);
      total_r  <= TOT_W'(RST_TOT);
      base_r   <= ADDR_W'(RST_BASE);
      wr_idx_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      src_r    <= ADDR_W'(RST_BASE);
    end else if (cfg_hit) begin
      // A dimension write restarts both the load and the read-out.
      rows_r   <= rows_nxt;
      cols_r   <= cols_nxt;
      total_r  <= total_nxt;
      base_r   <= base_nxt;
      wr_idx_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      src_r    <= base_nxt;
    end else begin
      if (cmd.wr_pixel) begin
        wr_idx_r <= wr_wrap ? '0 : wr_idx_r + ADDR_W'(1);
      end
      // The read walks up a source column, then moves one column right.
      if (cmd.rd_pixel) begin
        if (col_end) begin
          col_r <= '0;
          if (row_end) begin
            row_r <= '0;
            src_r <= base_r;
          end else begin
            row_r <= row_r + IDX_W'(1);
            src_r <= base_r + ADDR_W'(row_r) + ADDR_W'(1);
          end
        end else begin
          col_r <= col_r + IDX_W'(1);
          src_r <= src_r - ADDR_W'(cols_r);
        end
      end
    end
  end

  // Pixel store with registered read data; the read register is the output slot.
  always_ff @(posedge clk) begin
    if (cmd.wr_pixel) begin
      mem[wr_idx_r] <= pixel_in;
    end
    if (cmd.rd_pixel) begin
      pixel_out <= mem[src_r];
      last_out  <= col_end & row_end;
    end
  end

endmodule

@@ hw/rtl/image_rotate_90_clockwise_core.sv @@
// ----------------------------------------------------------------------------
// image_rotate_90_clockwise_core
// Loads a rows-by-cols image and streams it back rotated 90 degrees clockwise.
// ----------------------------------------------------------------------------
// A write item (in_tuser = 0) stores the next source pixel in row-major order
// and is taken every clock while no result waits. A read item (in_tuser = 1)
// returns the next pixel of the rotated image, which has cols rows and rows
// columns, in the cycle after acceptance from the registered read of the
// single-port pixel store; with out_tready held high, reads also stream at one
// item per clock, and out_tlast marks the final pixel of the rotated image.
// While a result waits on out_tready, no item of either kind is taken. The
// store holds MAX_DIM*MAX_DIM pixels, is not cleared after reset, and a pixel
// must be written before it is read. Writing rows or cols (saturated to
// 1..MAX_DIM) restarts both counters.
// ----------------------------------------------------------------------------
module image_rotate_90_clockwise_core
  import irc_pkg::*;
#(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] in_tdata,   // pixel_in
  input  logic                                  in_tuser,   // op
  // Result channel.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((PIXEL_BITS + 7) / 8) * 8-1:0] out_tdata,  // pixel_out
  output logic                                  out_tlast,
  // Configuration port.
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data
);

  localparam int unsigned TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;

  cmd_t                  cmd;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  rd_acc;
  logic                  wr_acc;

  // Handshake controller.
  irc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  // Counters and pixel store.
  irc_dp #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pixel_in  (in_tdata[PIXEL_BITS-1:0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_out (pixel_out),
    .last_out  (out_tlast)
  );

  // Zero-fill the pixel to whole bytes.
  assign out_tdata = TDATA_W'(pixel_out);

  // Accepted items seen on the ports, by kind.
  assign rd_acc = in_tvalid & in_tready & (in_tuser == OP_READ);
  assign wr_acc = in_tvalid & in_tready & (in_tuser == OP_WRITE);

  // Checks on the controller's use of the output slot.
`include "image_rotate_90_clockwise_core_assert.svh"

  `IRC_ASSERT_NEXT(a_read_shows, rd_acc, out_tvalid, "read item gave no result")
  `IRC_ASSERT_NEXT(a_write_quiet, wr_acc, !out_tvalid, "write item gave a result")
  `IRC_ASSERT_SAME(a_free_slot_ready, !out_tvalid, in_tready, "input stalled while idle")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for image_rotate_90_clockwise_core
// Loads source images pixel by pixel and reads them back rotated. A
// scoreboard keeps its own copy of the pixel store and the two counters,
// predicts each rotated pixel and its frame-end flag, and compares them with
// the result stream. Both stream sides idle at random throughout the run.
// ----------------------------------------------------------------------------
module tb_top
  import irc_pkg::*;
;

  localparam int unsigned MAX_DIM    = 64;
  localparam int unsigned PIXEL_BITS = 16;
  localparam int unsigned DATA_W     = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int unsigned STORE_SIZE = MAX_DIM * MAX_DIM;

  // Register indexes that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 20;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } rot_pixel_t;

  // Scoreboard: mirror of the pixel store and the write and read counters.
  class rotate_scoreboard;
    logic [PIXEL_BITS-1:0] image_copy [STORE_SIZE];
    bit                    stored     [STORE_SIZE];
    int unsigned           n_rows;
    int unsigned           n_cols;
    int unsigned           wr_pos;
    int unsigned           rd_row;
    int unsigned           rd_col;
    rot_pixel_t            rotated_q [$];
    int unsigned           errors;
    int unsigned           n_writes;
    int unsigned           n_reads;
    int unsigned           n_frames;
    int unsigned           n_settings;

    function new();
      n_rows     = MAX_DIM;
      n_cols     = MAX_DIM;
      wr_pos     = 0;
      rd_row     = 0;
      rd_col     = 0;
      errors     = 0;
      n_writes   = 0;
      n_reads    = 0;
      n_frames   = 0;
      n_settings = 0;
      foreach (stored[i]) stored[i] = 1'b0;
    endfunction

    // Out-of-range dimensions saturate to 1..MAX_DIM.
    function int unsigned clamp_dim(logic [CFG_DATA_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return 32'(raw);
    endfunction

    // A dimension write restarts both counters; other indexes do nothing.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] raw);
      if (idx == REG_ROWS) n_rows = clamp_dim(raw);
      else if (idx == REG_COLS) n_cols = clamp_dim(raw);
      else return;
      wr_pos = 0;
      rd_row = 0;
      rd_col = 0;
      n_settings++;
    endfunction

    function int unsigned frame_size();
      return n_rows * n_cols;
    endfunction

    // Source address of the next rotated pixel.
    function int unsigned next_source();
      return (n_rows - 1 - rd_col) * n_cols + rd_row;
    endfunction

    function bit read_allowed();
      return stored[next_source()];
    endfunction

    function int unsigned pending();
      return rotated_q.size();
    endfunction

    // Apply one accepted item; a read queues the rotated pixel it returns.
    function void note_item(logic op, logic [PIXEL_BITS-1:0] pix);
      rot_pixel_t want;
      if (op == OP_WRITE) begin
        image_copy[wr_pos] = pix;
        stored[wr_pos]     = 1'b1;
        n_writes++;
        wr_pos++;
        if (wr_pos >= frame_size()) wr_pos = 0;
      end else begin
        want.pixel = image_copy[next_source()];
        want.last  = (rd_row == n_cols - 1) && (rd_col == n_rows - 1);
        rotated_q.push_back(want);
        n_reads++;
        rd_col++;
        if (rd_col >= n_rows) begin
          rd_col = 0;
          rd_row++;
          if (rd_row >= n_cols) rd_row = 0;
        end
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Compare one result item with the oldest predicted pixel.
    task check_result(logic [PIXEL_BITS-1:0] pix, logic last);
      rot_pixel_t want;
      if (rotated_q.size() == 0) begin
        report($sformatf("result %h (last %b) with no read outstanding", pix, last));
        return;
      end
      want = rotated_q.pop_front();
      if (pix !== want.pixel)
        report($sformatf("pixel_out %h, predicted %h", pix, want.pixel));
      if (last !== want.last)
        report($sformatf("last %b, predicted %b", last, want.last));
      if (want.last) n_frames++;
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata   = '0;
  logic                  in_tuser   = OP_WRITE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  rotate_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned n_items    = 0;
  int unsigned rx_mode    = 0;
  int unsigned rx_left    = 0;
  int unsigned rx_tick    = 0;
  int unsigned quiet      = 0;

  image_rotate_90_clockwise_core #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // pixel_in
    .in_tuser   (in_tuser),    // op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // pixel_out
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: the receiver switches between stall patterns now and then.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (rx_tick % 4) != 0;
      default: out_tready <= (rx_tick % 16) < 3;
    endcase
  end

  // Every accepted result item is checked against the prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[PIXEL_BITS-1:0], out_tlast);
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one item in bursts with random gaps; returns once it is accepted.
  task automatic send_item(input logic op, input logic [PIXEL_BITS-1:0] pix);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= DATA_W'(pix);
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, pix);
    n_items++;
  endtask

  // Stop offering items and let every outstanding result come back.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] raw);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= raw;
    sb.set_reg(idx, raw);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] raw_rows,
                           input logic [CFG_DATA_W-1:0] raw_cols,
                           input bit rows_only);
    wait_idle();
    write_reg(REG_ROWS, raw_rows);
    if ($urandom_range(0, 4) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                CFG_DATA_W'($urandom_range(0, 127)));
    if (!rows_only) write_reg(REG_COLS, raw_cols);
  endtask

  // Whole frames: load every pixel, then read the rotated image back. With
  // overlap, writes of the next frame are mixed into the read-out.
  task automatic run_frames(input int unsigned nframes, input bit overlap);
    int unsigned total;
    total = sb.frame_size();
    repeat (nframes) begin
      repeat (total) send_item(OP_WRITE, PIXEL_BITS'($urandom_range(0, 65535)));
      repeat (total) begin
        if (overlap && $urandom_range(0, 2) == 0)
          send_item(OP_WRITE, PIXEL_BITS'($urandom_range(0, 65535)));
        send_item(OP_READ, PIXEL_BITS'($urandom_range(0, 65535)));
      end
    end
  endtask

  // Random mix of writes and reads; a read only where its pixel was stored.
  task automatic run_noise(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 1) && sb.read_allowed())
        send_item(OP_READ, PIXEL_BITS'($urandom_range(0, 65535)));
      else
        send_item(OP_WRITE, PIXEL_BITS'($urandom_range(0, 65535)));
    end
  endtask

  task automatic random_phase();
    int unsigned           sel;
    logic [CFG_DATA_W-1:0] r;
    logic [CFG_DATA_W-1:0] c;
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      r = CFG_DATA_W'($urandom_range(1, 8));
      c = CFG_DATA_W'($urandom_range(1, 8));
    end else if (sel == 6) begin
      r = CFG_DATA_W'($urandom_range(1, 4));
      c = CFG_DATA_W'($urandom_range(9, 64));
    end else if (sel == 7) begin
      r = CFG_DATA_W'($urandom_range(9, 64));
      c = CFG_DATA_W'($urandom_range(1, 4));
    end else if (sel == 8) begin
      r = CFG_DATA_W'($urandom_range(0, 127));
      c = CFG_DATA_W'($urandom_range(0, 7));
    end else begin
      r = CFG_DATA_W'($urandom_range(0, 7));
      c = CFG_DATA_W'($urandom_range(0, 127));
    end
    configure(r, c, (r <= 8) && ($urandom_range(0, 4) == 0));
    // Whole frames only for small images; large ones get a short random mix.
    if ($urandom_range(0, 4) != 0 && sb.frame_size() <= 64) begin
      run_frames($urandom_range(1, 3), 1'($urandom_range(0, 1)));
      run_noise($urandom_range(0, 8));
    end else begin
      run_noise($urandom_range(4, 64));
    end
  endtask

  initial begin
    int unsigned start_items;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Dimensions after reset are 64 by 64: a short load at that size.
    run_noise(16);

    // Directed: a 3x2 image with extreme pixel values, then reads that run
    // past the frame end and wrap, across writes to unused indexes.
    wait_idle();
    write_reg(REG_ROWS, 7'd3);
    write_reg(REG_COLS, 7'd2);
    send_item(OP_WRITE, 16'h0000);
    send_item(OP_WRITE, 16'hFFFF);
    send_item(OP_WRITE, 16'hAAAA);
    send_item(OP_WRITE, 16'h5555);
    send_item(OP_WRITE, 16'h0001);
    send_item(OP_WRITE, 16'h8000);
    repeat (4) send_item(OP_READ, 16'hFFFF);
    wait_idle();
    write_reg(REG_SPARE_B, 7'h7F);
    repeat (3) send_item(OP_READ, 16'h0000);
    wait_idle();
    write_reg(REG_SPARE_A, 7'h00);
    send_item(OP_WRITE, 16'h1234);
    send_item(OP_READ, 16'h0000);

    // Extreme settings, including saturation of zero and oversized values.
    configure(7'd1, 7'd1, 1'b0);
    run_frames(2, 1'b1);
    configure(7'd0, 7'd127, 1'b0);
    run_frames(1, 1'b0);
    run_noise(20);
    configure(7'd127, 7'd0, 1'b0);
    run_frames(1, 1'b1);

    // Random settings and traffic.
    start_items = n_items;
    while (n_items - start_items < RANDOM_ITEMS) random_phase();

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted pixels never came out", sb.pending()));

    $display("Run covered %0d pixel writes and %0d rotated reads over %0d dimension writes.",
             sb.n_writes, sb.n_reads, sb.n_settings);
    $display("Rotated frames completed: %0d; mismatches counted: %0d.",
             sb.n_frames, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
